/* design/haptic_viscous_sphere_force_top_defines.svh */
// ------------------------------------------------------------------------
// Assertion macros for the haptic sphere force block
// Both macros sample on the rising edge of clk and are disabled in reset.
// ------------------------------------------------------------------------
`ifndef HAPTIC_VISCOUS_SPHERE_FORCE_TOP_DEFINES_SVH
`define HAPTIC_VISCOUS_SPHERE_FORCE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HVSF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hvsf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HVSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hvsf: next-cycle check failed");

`endif

/* design/hvsf_pkg.sv */
// ------------------------------------------------------------------------
// hvsf_pkg
// Widths, register indexes and reset values shared by the sphere force block.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvsf_pkg;

	localparam int POS_W         = 19;
	localparam int FORCE_OUT_W   = 16;
	localparam int RADIUS_W      = 17;
	localparam int COORD_W       = 19;
	localparam int STIFF_W       = 12;
	localparam int COEF_IN_W     = 16;
	localparam int RATE_W        = 16;
	localparam int REG_IDX_W     = 3;
	localparam int REG_DATA_W    = 19;

	localparam int POS_FRAC_BITS = 4;
	localparam int PQ_W          = POS_W + POS_FRAC_BITS;
	localparam int PREV_W        = PQ_W + 1;

	// Shared serial units
	localparam int MUL_A_W       = 48;
	localparam int MUL_B_W       = 32;
	localparam int PROD_W        = 64;
	localparam int DIV_D_W       = 40;
	localparam int SQ_IN_W       = 40;
	localparam int SQ_OUT_W      = 20;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RADIUS    = 3'd0,
		REG_CENTER_Z  = 3'd1,
		REG_START_Z   = 3'd2,
		REG_STIFFNESS = 3'd3,
		REG_VISCOSITY = 3'd4,
		REG_DAMPING   = 3'd5,
		REG_RATE      = 3'd6
	} reg_idx_t;

	localparam logic [RADIUS_W-1:0]         RST_RADIUS    = 17'd40000;
	localparam logic signed [COORD_W-1:0]   RST_CENTER_Z  = 19'sd110000;
	localparam logic signed [COORD_W-1:0]   RST_START_Z   = 19'sd170000;
	localparam logic [STIFF_W-1:0]          RST_STIFFNESS = 12'd120;
	localparam logic [COEF_IN_W-1:0]        RST_VISCOSITY = 16'd15000;
	localparam logic [COEF_IN_W-1:0]        RST_DAMPING   = 16'd400;
	localparam logic [RATE_W-1:0]           RST_RATE      = 16'd1000;

endpackage

/* design/haptic_viscous_sphere_force_top.sv */
// ------------------------------------------------------------------------
// haptic_viscous_sphere_force_top
// Sphere contact force with spring and viscous damping, one sample per item.
// ------------------------------------------------------------------------
// Usage:
// Input items (pos_x, pos_y, pos_z) are taken when in_valid is high and
// in_stall is low; results (force_x/y/z, inside_res) leave when out_valid is
// high and out_stall is low. Registers are to be written through wr_en,
// wr_index and wr_data only while the block is idle; the block itself does
// not enforce this. Unknown indexes are ignored. Until armed, an item only
// records the previous position and gives no result; it arms the block
// when pos_z is above the start height. Armed, every item gives one
// result, worked out by the shared one-bit-per-cycle divider (three
// divisions per item outside the sphere and up to twelve inside), the
// serial multiplier and the square root. One item is worked on at a time;
// the next one is taken while a finished result still waits in the output
// register. If that register is still full when the next result is ready,
// work pauses until it is taken.
// Reset clears the armed flag and loads the register defaults; the filtered
// previous position is defined by the first item after reset.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "haptic_viscous_sphere_force_top_defines.svh"

module haptic_viscous_sphere_force_top import hvsf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [POS_W-1:0]       pos_x,
	input  logic signed [POS_W-1:0]       pos_y,
	input  logic signed [POS_W-1:0]       pos_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [FORCE_OUT_W-1:0] force_x,
	output logic signed [FORCE_OUT_W-1:0] force_y,
	output logic signed [FORCE_OUT_W-1:0] force_z,
	output logic                          inside_res,
	input  logic                          wr_en,
	input  logic [REG_IDX_W-1:0]          wr_index,
	input  logic [REG_DATA_W-1:0]         wr_data
);

	localparam int OFF_W     = POS_W + 1;
	localparam int R2_W      = 2 * RADIUS_W;
	localparam int CF_W      = COEF_IN_W + 2;
	localparam int COEF_W    = 26;
	localparam int G_W       = 20;
	localparam int MAG_W     = 40;
	localparam int SPR_SHIFT = 12;
	localparam int SPR_W     = MAG_W - SPR_SHIFT + 1;
	localparam int DIFF_W    = PREV_W + 1;
	localparam int VP_W      = DIFF_W + RATE_W + 1;
	localparam int DAMP_W    = 43;
	localparam int FORCE_W   = DAMP_W + 2;
	localparam int FLT_W     = PREV_W + 3;
	localparam int VEL_HALF  = (1 << POS_FRAC_BITS) >> 1;
	localparam int MAG_DIV   = 1000;
	localparam int DAMP_DIV  = 2000000;
	localparam int FLT_DIV   = 10;
	localparam int FLT_ROUND = 5;
	localparam int SPRING_MIN_S = 1000000;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_R2, ST_SQRT, ST_CF1, ST_CF2,
		ST_PP, ST_G, ST_KP, ST_KPG, ST_MAG, ST_AXIS, ST_SM, ST_SD,
		ST_VM, ST_DM, ST_DD, ST_FLT, ST_DONE
	} state_t;

	state_t state_q;
	logic   issued_q;
	logic   armed_q;
	logic   out_valid_q;
	logic   inside_q;
	logic [1:0] ax_q;

	logic [RADIUS_W-1:0]       radius_q;
	logic signed [COORD_W-1:0] center_z_q;
	logic signed [COORD_W-1:0] start_z_q;
	logic [STIFF_W-1:0]        stiffness_q;
	logic [COEF_IN_W-1:0]      viscosity_q;
	logic [COEF_IN_W-1:0]      damping_q;
	logic [RATE_W-1:0]         rate_q;

	logic signed [POS_W-1:0]   pos_q [3];
	logic signed [OFF_W-1:0]   off_q [3];
	logic signed [PREV_W-1:0]  prev_q [3];
	logic [SQ_IN_W-1:0]        s_q;
	logic [R2_W-1:0]           r2_q;
	logic [RADIUS_W-1:0]       dist_q;
	logic [RADIUS_W-1:0]       pen_q;
	logic [COEF_W-1:0]         coef_q;
	logic [G_W-1:0]            g_q;
	logic [MAG_W-1:0]          mag_q;
	logic signed [SPR_W-1:0]   spr_q;
	logic signed [VP_W-1:0]    vel_q;
	logic [FORCE_OUT_W-1:0]    fr_q [3];
	logic [FORCE_OUT_W-1:0]    force_x_q, force_y_q, force_z_q;
	logic                      inside_res_q;

	logic               mul_go, div_go, sq_go;
	logic               mul_start, div_start, sq_start;
	logic               mul_done, div_done, sq_done;
	logic               op_done;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [PROD_W-1:0]  div_n;
	logic [DIV_D_W-1:0] div_d;
	logic [PROD_W-1:0]  div_q;
	logic [SQ_OUT_W-1:0] sq_root;

	logic [OFF_W-1:0]         off_abs [3];
	logic                     use_spring;
	logic [CF_W-1:0]          cf_sum;
	logic [R2_W+2:0]          five_r2;
	logic signed [PQ_W-1:0]   pq_in [3];
	logic signed [PQ_W-1:0]   pq_sel;
	logic signed [PREV_W-1:0] prev_sel;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        diff_abs;
	logic signed [VP_W-1:0]   vprod;
	logic signed [VP_W-1:0]   vel_t;
	logic [VP_W-1:0]          vel_abs;
	logic [MAG_W-SPR_SHIFT-1:0] spr_mag;
	logic [DAMP_W-1:0]        damp_mag;
	logic signed [FORCE_W-1:0] force_full;
	logic signed [FLT_W-1:0]  flt_a;
	logic [FLT_W-1:0]         flt_n;
	logic [FLT_W-1:0]         flt_q;
	logic signed [PREV_W-1:0] flt_new;

	// Round a Q8 force half away from zero to millinewtons and saturate.
	function automatic logic [FORCE_OUT_W-1:0] to_mn(input logic signed [FORCE_W-1:0] f);
		logic [FORCE_W-1:0] m;
		logic [FORCE_W-1:0] r;
		logic [FORCE_OUT_W-1:0] res;
		m = f[FORCE_W-1] ? FORCE_W'(-f) : FORCE_W'(f);
		r = (m + FORCE_W'(128)) >> 8;
		if (!f[FORCE_W-1]) begin
			res = (r > FORCE_W'(32767)) ? FORCE_OUT_W'(32767) : r[FORCE_OUT_W-1:0];
		end else begin
			res = (r > FORCE_W'(32768)) ? FORCE_OUT_W'(32768) : FORCE_OUT_W'(-r[FORCE_OUT_W-1:0]);
		end
		return res;
	endfunction

	hvsf_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
	);

	hvsf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(div_n), .d(div_d), .done(div_done), .q(div_q)
	);

	hvsf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.x(s_q), .done(sq_done), .root(sq_root)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_abs[i] = off_q[i][OFF_W-1] ? OFF_W'(-off_q[i]) : OFF_W'(off_q[i]);
		end
	end

	assign pq_in[0] = PQ_W'(pos_x) <<< POS_FRAC_BITS;
	assign pq_in[1] = PQ_W'(pos_y) <<< POS_FRAC_BITS;
	assign pq_in[2] = PQ_W'(pos_z) <<< POS_FRAC_BITS;

	assign use_spring = s_q > SQ_IN_W'(SPRING_MIN_S);
	assign cf_sum     = {1'b0, damping_q, 1'b0} + {2'b00, viscosity_q};
	assign five_r2    = {1'b0, r2_q, 2'b00} + {3'b000, r2_q};

	// Per-axis velocity, damping and filter terms
	assign pq_sel   = PQ_W'(pos_q[ax_q]) <<< POS_FRAC_BITS;
	assign prev_sel = prev_q[ax_q];
	assign diff     = DIFF_W'(pq_sel) - DIFF_W'(prev_sel);
	assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign vprod    = diff[DIFF_W-1] ? -VP_W'(mul_p[VP_W-1:0]) : VP_W'(mul_p[VP_W-1:0]);
	assign vel_t    = vprod + VP_W'(VEL_HALF);
	assign vel_abs  = vel_q[VP_W-1] ? VP_W'(-vel_q) : VP_W'(vel_q);
	assign spr_mag  = div_q[MAG_W-1:SPR_SHIFT];
	assign damp_mag = div_q[DAMP_W-1:0];
	assign force_full = FORCE_W'(spr_q)
		- (vel_q[VP_W-1] ? -FORCE_W'(damp_mag) : FORCE_W'(damp_mag));

	// Low-pass filter: floor((3*prev + 7*new + 5) / 10), done in sign-magnitude.
	assign flt_a = (FLT_W'(prev_sel) <<< 1) + FLT_W'(prev_sel)
		+ (FLT_W'(pq_sel) <<< 3) - FLT_W'(pq_sel) + FLT_W'(FLT_ROUND);
	assign flt_n = flt_a[FLT_W-1] ? (FLT_W'(-flt_a) + FLT_W'(FLT_DIV - 1)) : FLT_W'(flt_a);
	assign flt_q = div_q[FLT_W-1:0];
	assign flt_new = flt_a[FLT_W-1] ? PREV_W'(-flt_q) : PREV_W'(flt_q);

	always_comb begin
		mul_go = 1'b0;
		div_go = 1'b0;
		sq_go  = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		div_n  = '0;
		div_d  = '0;
		case (state_q)
			ST_SQX: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(off_abs[0]);
				mul_b  = MUL_B_W'(off_abs[0]);
			end
			ST_SQY: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(off_abs[1]);
				mul_b  = MUL_B_W'(off_abs[1]);
			end
			ST_SQZ: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(off_abs[2]);
				mul_b  = MUL_B_W'(off_abs[2]);
			end
			ST_R2: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(radius_q);
				mul_b  = MUL_B_W'(radius_q);
			end
			ST_SQRT: begin
				sq_go = 1'b1;
			end
			ST_CF1: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(cf_sum);
				mul_b  = MUL_B_W'(pen_q);
			end
			ST_CF2: begin
				div_go = 1'b1;
				div_n  = {mul_p[PROD_W-9:0], 8'b0};
				div_d  = DIV_D_W'(radius_q);
			end
			ST_PP: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(pen_q);
				mul_b  = MUL_B_W'(pen_q);
			end
			ST_G: begin
				div_go = 1'b1;
				div_n  = {mul_p[PROD_W-23:0], 22'b0};
				div_d  = DIV_D_W'(five_r2);
			end
			ST_KP: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(stiffness_q);
				mul_b  = MUL_B_W'(pen_q);
			end
			ST_KPG: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(mul_p[STIFF_W+RADIUS_W-1:0]);
				mul_b  = MUL_B_W'({1'b1, g_q});
			end
			ST_MAG: begin
				div_go = 1'b1;
				div_n  = mul_p;
				div_d  = DIV_D_W'(MAG_DIV);
			end
			ST_SM: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(mag_q);
				mul_b  = MUL_B_W'(off_abs[ax_q]);
			end
			ST_SD: begin
				div_go = 1'b1;
				div_n  = mul_p;
				div_d  = DIV_D_W'(dist_q);
			end
			ST_VM: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(diff_abs);
				mul_b  = MUL_B_W'(rate_q);
			end
			ST_DM: begin
				mul_go = 1'b1;
				mul_a  = MUL_A_W'(vel_abs);
				mul_b  = MUL_B_W'(coef_q);
			end
			ST_DD: begin
				div_go = 1'b1;
				div_n  = mul_p;
				div_d  = DIV_D_W'(DAMP_DIV);
			end
			ST_FLT: begin
				div_go = 1'b1;
				div_n  = PROD_W'(flt_n);
				div_d  = DIV_D_W'(FLT_DIV);
			end
			default: begin
			end
		endcase
	end

	assign mul_start = mul_go && !issued_q;
	assign div_start = div_go && !issued_q;
	assign sq_start  = sq_go && !issued_q;
	assign op_done   = issued_q
		&& ((mul_go && mul_done) || (div_go && div_done) || (sq_go && sq_done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issued_q     <= 1'b0;
			armed_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			inside_q     <= 1'b0;
			ax_q         <= '0;
			radius_q     <= RST_RADIUS;
			center_z_q   <= RST_CENTER_Z;
			start_z_q    <= RST_START_Z;
			stiffness_q  <= RST_STIFFNESS;
			viscosity_q  <= RST_VISCOSITY;
			damping_q    <= RST_DAMPING;
			rate_q       <= RST_RATE;
			pos_q        <= '{default: '0};
			off_q        <= '{default: '0};
			s_q          <= '0;
			r2_q         <= '0;
			dist_q       <= '0;
			pen_q        <= '0;
			coef_q       <= '0;
			g_q          <= '0;
			mag_q        <= '0;
			spr_q        <= '0;
			vel_q        <= '0;
			fr_q         <= '{default: '0};
			force_x_q    <= '0;
			force_y_q    <= '0;
			force_z_q    <= '0;
			inside_res_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_RADIUS:    radius_q    <= wr_data[RADIUS_W-1:0];
					REG_CENTER_Z:  center_z_q  <= wr_data[COORD_W-1:0];
					REG_START_Z:   start_z_q   <= wr_data[COORD_W-1:0];
					REG_STIFFNESS: stiffness_q <= wr_data[STIFF_W-1:0];
					REG_VISCOSITY: viscosity_q <= wr_data[COEF_IN_W-1:0];
					REG_DAMPING:   damping_q   <= wr_data[COEF_IN_W-1:0];
					REG_RATE:      rate_q      <= wr_data[RATE_W-1:0];
					default: begin
					end
				endcase
			end

			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mul_start || div_start || sq_start) begin
				issued_q <= 1'b1;
			end
			if (op_done) begin
				issued_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pos_q[0] <= pos_x;
						pos_q[1] <= pos_y;
						pos_q[2] <= pos_z;
						off_q[0] <= OFF_W'(pos_x);
						off_q[1] <= OFF_W'(pos_y);
						off_q[2] <= OFF_W'(pos_z) - OFF_W'(center_z_q);
						if (!armed_q) begin
							if (pos_z > start_z_q) begin
								armed_q <= 1'b1;
							end
						end else begin
							state_q <= ST_SQX;
						end
					end
				end
				ST_SQX: if (op_done) begin
					s_q     <= mul_p[SQ_IN_W-1:0];
					state_q <= ST_SQY;
				end
				ST_SQY: if (op_done) begin
					s_q     <= s_q + mul_p[SQ_IN_W-1:0];
					state_q <= ST_SQZ;
				end
				ST_SQZ: if (op_done) begin
					s_q     <= s_q + mul_p[SQ_IN_W-1:0];
					state_q <= ST_R2;
				end
				ST_R2: if (op_done) begin
					r2_q     <= mul_p[R2_W-1:0];
					inside_q <= s_q < SQ_IN_W'(mul_p[R2_W-1:0]);
					ax_q     <= '0;
					state_q  <= (s_q < SQ_IN_W'(mul_p[R2_W-1:0])) ? ST_SQRT : ST_AXIS;
				end
				ST_SQRT: if (op_done) begin
					dist_q  <= sq_root[RADIUS_W-1:0];
					pen_q   <= radius_q - sq_root[RADIUS_W-1:0];
					state_q <= ST_CF1;
				end
				ST_CF1: if (op_done) begin
					state_q <= ST_CF2;
				end
				ST_CF2: if (op_done) begin
					coef_q  <= div_q[COEF_W-1:0];
					state_q <= use_spring ? ST_PP : ST_AXIS;
				end
				ST_PP: if (op_done) begin
					state_q <= ST_G;
				end
				ST_G: if (op_done) begin
					g_q     <= div_q[G_W-1:0];
					state_q <= ST_KP;
				end
				ST_KP: if (op_done) begin
					state_q <= ST_KPG;
				end
				ST_KPG: if (op_done) begin
					state_q <= ST_MAG;
				end
				ST_MAG: if (op_done) begin
					mag_q   <= div_q[MAG_W-1:0];
					state_q <= ST_AXIS;
				end
				ST_AXIS: begin
					spr_q <= '0;
					if (!inside_q) begin
						fr_q[ax_q] <= '0;
						state_q    <= ST_FLT;
					end else if (use_spring) begin
						state_q <= ST_SM;
					end else begin
						state_q <= ST_VM;
					end
				end
				ST_SM: if (op_done) begin
					state_q <= ST_SD;
				end
				ST_SD: if (op_done) begin
					spr_q   <= off_q[ax_q][OFF_W-1] ? -SPR_W'(spr_mag) : SPR_W'(spr_mag);
					state_q <= ST_VM;
				end
				ST_VM: if (op_done) begin
					vel_q   <= vel_t >>> POS_FRAC_BITS;
					state_q <= ST_DM;
				end
				ST_DM: if (op_done) begin
					state_q <= ST_DD;
				end
				ST_DD: if (op_done) begin
					fr_q[ax_q] <= to_mn(force_full);
					state_q    <= ST_FLT;
				end
				ST_FLT: if (op_done) begin
					if (ax_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_AXIS;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						force_x_q    <= fr_q[0];
						force_y_q    <= fr_q[1];
						force_z_q    <= fr_q[2];
						inside_res_q <= inside_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Filtered previous position: loaded by every item while unarmed, then
	// updated for each axis as that axis finishes in every armed item.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !armed_q) begin
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= PREV_W'(pq_in[i]);
			end
		end else if (state_q == ST_FLT && op_done) begin
			prev_q[ax_q] <= flt_new;
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign force_x    = force_x_q;
	assign force_y    = force_y_q;
	assign force_z    = force_z_q;
	assign inside_res = inside_res_q;

	`HVSF_ASSERT_NEXT(a_unarmed_no_work, in_valid && !in_stall && !armed_q, state_q == ST_IDLE)
	`HVSF_ASSERT_IMPL(a_outside_zero, out_valid && !inside_res, force_x == '0 && force_y == '0 && force_z == '0)
	`HVSF_ASSERT_IMPL(a_dist_in_radius, state_q == ST_CF1, dist_q < radius_q && pen_q != '0)

endmodule

/* design/hvsf_mul.sv */
// ------------------------------------------------------------------------
// hvsf_mul
// Shift-and-add multiplier, one multiplier bit per cycle, stops early.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvsf_mul import hvsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               done,
	output logic [PROD_W-1:0]  p
);

	logic              busy_q;
	logic              done_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= PROD_W'(a);
			b_q   <= b;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

/* design/hvsf_div.sv */
// ------------------------------------------------------------------------
// hvsf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvsf_div import hvsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PROD_W-1:0]  n,
	input  logic [DIV_D_W-1:0] d,
	output logic               done,
	output logic [PROD_W-1:0]  q
);

	localparam int CNT_W = $clog2(PROD_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  n_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] d_q;
	logic [DIV_D_W:0]   rem2;
	logic               ge;
	logic [DIV_D_W:0]   rem_next;

	assign rem2     = {rem_q, n_q[PROD_W-1]};
	assign ge       = rem2 >= {1'b0, d_q};
	assign rem_next = ge ? (rem2 - {1'b0, d_q}) : rem2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next[DIV_D_W-1:0];
			n_q   <= {n_q[PROD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = n_q;

endmodule

/* design/hvsf_sqrt.sv */
// ------------------------------------------------------------------------
// hvsf_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvsf_sqrt import hvsf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SQ_IN_W-1:0]  x,
	output logic                done,
	output logic [SQ_OUT_W-1:0] root
);

	localparam int CNT_W = $clog2(SQ_OUT_W);
	localparam int REM_W = SQ_OUT_W + 2;

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SQ_IN_W-1:0]  x_q;
	logic [REM_W-1:0]    rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [REM_W+1:0]    rem2;
	logic [REM_W+1:0]    trial;
	logic                ge;
	logic [REM_W+1:0]    rem_next;

	assign rem2     = {rem_q, x_q[SQ_IN_W-1 -: 2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign ge       = rem2 >= trial;
	assign rem_next = ge ? (rem2 - trial) : rem2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SQ_OUT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= rem_next[REM_W-1:0];
			root_q <= {root_q[SQ_OUT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* sim/haptic_viscous_sphere_force_top_test.sv */
// ------------------------------------------------------------------------
// haptic_viscous_sphere_force_top_test
// Drives grip position items into the sphere force block under random
// sender gaps and receiver stalls, across several register settings. The
// expected forces are computed by a scoreboard that tracks the arming flag
// and the filtered previous position. Each result is compared field by field.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module haptic_viscous_sphere_force_top_test;
	import hvsf_pkg::*;

	localparam longint CYCLE_LIMIT = 8000000;
	localparam int     HOLD_START  = 40000;
	localparam int     HOLD_LEN    = 6000;

	typedef struct {
		logic signed [FORCE_OUT_W-1:0] fx;
		logic signed [FORCE_OUT_W-1:0] fy;
		logic signed [FORCE_OUT_W-1:0] fz;
		logic                          ins;
	} force_item_t;

	class sphere_force_scoreboard;
		force_item_t pending_forces[$];
		int          errors;
		bit          armed;
		longint      prev_pos[3];
		longint      radius, center_z, start_z, stiffness, viscosity, damping, rate;

		function new();
			errors    = 0;
			armed     = 0;
			radius    = RST_RADIUS;
			center_z  = RST_CENTER_Z;
			start_z   = RST_START_Z;
			stiffness = RST_STIFFNESS;
			viscosity = RST_VISCOSITY;
			damping   = RST_DAMPING;
			rate      = RST_RATE;
		endfunction

		function void write_reg(reg_idx_t idx, logic [REG_DATA_W-1:0] val);
			case (idx)
				REG_RADIUS:    radius    = val[RADIUS_W-1:0];
				REG_CENTER_Z:  center_z  = $signed(val[COORD_W-1:0]);
				REG_START_Z:   start_z   = $signed(val[COORD_W-1:0]);
				REG_STIFFNESS: stiffness = val[STIFF_W-1:0];
				REG_VISCOSITY: viscosity = val[COEF_IN_W-1:0];
				REG_DAMPING:   damping   = val[COEF_IN_W-1:0];
				REG_RATE:      rate      = val[RATE_W-1:0];
				default: ;
			endcase
		endfunction

		function longint div_floor(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && a < 0)
				q = q - 1;
			return q;
		endfunction

		function longint int_sqrt(longint unsigned x);
			longint unsigned res, bitv;
			res  = 0;
			bitv = 64'd1 << 62;
			while (bitv > x)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (x >= res + bitv) begin
					x   = x - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return longint'(res);
		endfunction

		function logic signed [FORCE_OUT_W-1:0] round_sat(longint q8);
			longint r;
			if (q8 >= 0)
				r = (q8 + 128) / 256;
			else
				r = -((-q8 + 128) / 256);
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return r[FORCE_OUT_W-1:0];
		endfunction

		function int pending();
			return pending_forces.size();
		endfunction

		function void note_input(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
				logic signed [POS_W-1:0] pz);
			longint pos[3], pq[3], off[3], frc[3];
			longint s, dist_um, pen, coef, g, mag, diff, vel, dmp, spr;
			bit     in_sphere, use_spring;
			force_item_t res;
			pos[0] = px;
			pos[1] = py;
			pos[2] = pz;
			for (int i = 0; i < 3; i++)
				pq[i] = pos[i] * (longint'(1) << POS_FRAC_BITS);
			if (!armed) begin
				for (int i = 0; i < 3; i++)
					prev_pos[i] = pq[i];
				if (pos[2] > start_z)
					armed = 1;
				return;
			end
			off[0] = pos[0];
			off[1] = pos[1];
			off[2] = pos[2] - center_z;
			s = 0;
			for (int i = 0; i < 3; i++) begin
				s      = s + off[i] * off[i];
				frc[i] = 0;
			end
			in_sphere = s < radius * radius;
			if (in_sphere) begin
				dist_um    = int_sqrt(s);
				pen        = radius - dist_um;
				coef       = ((2 * damping + viscosity) * pen * 256) / radius;
				use_spring = s > 1000000;
				mag        = 0;
				if (use_spring) begin
					g   = ((4 * pen * pen) << 20) / (5 * radius * radius);
					mag = (stiffness * pen * ((longint'(1) << 20) + g)) / 1000;
				end
				for (int i = 0; i < 3; i++) begin
					diff = pq[i] - prev_pos[i];
					vel  = div_floor(diff * rate + (1 << (POS_FRAC_BITS - 1)),
						longint'(1) << POS_FRAC_BITS);
					dmp  = (coef * vel) / 2000000;
					spr  = use_spring ? ((mag * off[i]) / dist_um) / 4096 : 0;
					frc[i] = spr - dmp;
				end
			end
			res.fx  = in_sphere ? round_sat(frc[0]) : '0;
			res.fy  = in_sphere ? round_sat(frc[1]) : '0;
			res.fz  = in_sphere ? round_sat(frc[2]) : '0;
			res.ins = in_sphere;
			pending_forces.push_back(res);
			for (int i = 0; i < 3; i++)
				prev_pos[i] = div_floor(3 * prev_pos[i] + 7 * pq[i] + 5, 10);
		endfunction

		function void check_result(logic signed [FORCE_OUT_W-1:0] fx,
				logic signed [FORCE_OUT_W-1:0] fy, logic signed [FORCE_OUT_W-1:0] fz,
				logic ins);
			force_item_t want;
			if (pending_forces.size() == 0) begin
				$display("%0t: unexpected result fx=%0d fy=%0d fz=%0d inside=%0d",
					$time, fx, fy, fz, ins);
				errors++;
				return;
			end
			want = pending_forces.pop_front();
			if (fx !== want.fx) begin
				$display("%0t: force_x expected %0d actual %0d", $time, want.fx, fx);
				errors++;
			end
			if (fy !== want.fy) begin
				$display("%0t: force_y expected %0d actual %0d", $time, want.fy, fy);
				errors++;
			end
			if (fz !== want.fz) begin
				$display("%0t: force_z expected %0d actual %0d", $time, want.fz, fz);
				errors++;
			end
			if (ins !== want.ins) begin
				$display("%0t: inside_res expected %0d actual %0d", $time, want.ins, ins);
				errors++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [POS_W-1:0]       pos_x = '0;
	logic signed [POS_W-1:0]       pos_y = '0;
	logic signed [POS_W-1:0]       pos_z = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [FORCE_OUT_W-1:0] force_x;
	logic signed [FORCE_OUT_W-1:0] force_y;
	logic signed [FORCE_OUT_W-1:0] force_z;
	logic                          inside_res;
	logic                          wr_en = 1'b0;
	logic [REG_IDX_W-1:0]          wr_index = '0;
	logic [REG_DATA_W-1:0]         wr_data = '0;

	sphere_force_scoreboard sb = new();
	longint cycle_count = 0;
	int     burst_left = 0;
	int     last_x = 0, last_y = 0, last_z = 0;

	haptic_viscous_sphere_force_top dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The receiver switches among random stall habits and holds
	// off completely for one long stretch so that the block backs up.
	int stall_mode = 0;
	always @(posedge clk) begin
		if (cycle_count % 300 == 0)
			stall_mode <= $urandom_range(0, 3);
		if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN)
			out_stall <= 1'b1;
		else case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= (cycle_count % 7) < 3;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(force_x, force_y, force_z, inside_res);
	end

	function automatic logic signed [POS_W-1:0] clip_pos(int v);
		if (v > 262143)
			return 19'sd262143;
		if (v < -262144)
			return -19'sd262144;
		return v[POS_W-1:0];
	endfunction

	// Leaves in_valid high on return; the item was taken at the current edge.
	task automatic send_item(int x, int y, int z);
		pos_x    <= clip_pos(x);
		pos_y    <= clip_pos(y);
		pos_z    <= clip_pos(z);
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(clip_pos(x), clip_pos(y), clip_pos(z));
		last_x = int'(clip_pos(x));
		last_y = int'(clip_pos(y));
		last_z = int'(clip_pos(z));
	endtask

	task automatic sender_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 8);
		gap = $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_regs(logic [REG_DATA_W-1:0] vals[7]);
		for (int i = 0; i < 7; i++) begin
			wr_en    <= 1'b1;
			wr_index <= reg_idx_t'(i);
			wr_data  <= vals[i];
			@(posedge clk);
			sb.write_reg(reg_idx_t'(i), vals[i]);
		end
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_item();
		int mode, r2;
		mode = $urandom_range(0, 99);
		r2   = int'(sb.radius) + int'(sb.radius) / 4 + 1;
		if (mode < 50)
			send_item(last_x + $urandom_range(0, 400) - 200, last_y + $urandom_range(0, 400) - 200,
				last_z + $urandom_range(0, 400) - 200);
		else if (mode < 75)
			send_item($urandom_range(0, 2 * r2) - r2, $urandom_range(0, 2 * r2) - r2,
				int'(sb.center_z) + $urandom_range(0, 2 * r2) - r2);
		else if (mode < 85)
			send_item($urandom_range(0, 1200) - 600, $urandom_range(0, 1200) - 600,
				int'(sb.center_z) + $urandom_range(0, 1200) - 600);
		else
			send_item($signed(19'($urandom())), $signed(19'($urandom())),
				$signed(19'($urandom())));
		sender_gap();
	endtask

	initial begin
		logic [REG_DATA_W-1:0] regs[7];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unarmed items at or below the start height give no result.
		send_item(0, 0, 0);
		send_item(-262144, 262143, -262144);
		send_item(262143, -262144, 170000);
		wait_idle();

		regs = '{19'd40000, 19'd110000, 19'd100000, 19'd120, 19'd15000, 19'd400, 19'd1000};
		write_regs(regs);
		// A write to an index with no register behind it must change nothing.
		wr_en    <= 1'b1;
		wr_index <= '1;
		wr_data  <= '1;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);

		// The arming item itself gives no result.
		send_item(0, 0, 150000);
		send_item(0, 0, 110000);
		send_item(300, -200, 110500);
		send_item(10000, 0, 110000);
		send_item(0, -30000, 120000);
		send_item(0, 0, 80000);
		send_item(0, 0, 150000);
		send_item(262143, 262143, 262143);
		send_item(-262144, -262144, -262144);
		send_item(20000, 20000, 100000);
		send_item(20100, 19900, 100200);
		wait_idle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: regs = '{19'd40000, 19'd110000, 19'd100000, 19'd120, 19'd15000,
					19'd400, 19'd1000};
				1: regs = '{19'd131071, 19'sd262143, -19'sd262144, 19'd4095, 19'd65535,
					19'd65535, 19'd65535};
				2: regs = '{19'd0, -19'sd262144, 19'sd262143, 19'd0, 19'd0, 19'd0, 19'd0};
				3: regs = '{19'd1500, 19'd0, 19'd0, 19'd4095, 19'd0, 19'd100, 19'd0};
				4: regs = '{19'd1, 19'd0, 19'd0, 19'd1, 19'd1, 19'd1, 19'd1};
				default: begin
					regs[0] = REG_DATA_W'($urandom_range(1, 131071));
					regs[1] = REG_DATA_W'($urandom());
					regs[2] = REG_DATA_W'($urandom());
					regs[3] = REG_DATA_W'($urandom_range(0, 4095));
					regs[4] = REG_DATA_W'($urandom_range(0, 65535));
					regs[5] = REG_DATA_W'($urandom_range(0, 65535));
					regs[6] = REG_DATA_W'($urandom_range(0, 65535));
				end
			endcase
			write_regs(regs);
			for (int n = 0; n < 80; n++)
				random_item();
			wait_idle();
		end

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (1500) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
